// ----- hdl/sdiv_pkg.sv -----
// Shared declarations for the signed restoring divider.
// No dependencies; imported by every module of the divider.
`default_nettype none

package sdiv_pkg;

    // Default operand width
    localparam int DEFAULT_WIDTH = 16;

    // Control handed from stage to stage alongside the datapath
    typedef struct packed {
        logic valid;   // stage holds a live transaction
        logic neg;     // exactly one operand was negative
    } t_ctrl;

endpackage

`default_nettype wire

// ----- hdl/signed_restoring_divider_core.sv -----
// Top level of the signed restoring divider: input stage, chain of step cells,
// output register. Depends on sdiv_pkg, sdiv_front, sdiv_cell, sdiv_back.
//
// Divides a two's-complement dividend by a two's-complement divisor, both
// WIDTH bits, by restoring division on the operand magnitudes. The quotient
// is truncated toward zero; the remainder is the raw WIDTH-bit partial
// remainder (a magnitude, never sign-corrected). A zero divisor or a most
// negative operand gives whatever the restoring steps give; no flag is
// raised. The datapath is a row of WIDTH identical cells, one restoring step
// each, framed by a magnitude stage and an output register. One operand pair
// is taken every cycle while the master side takes results. Each stage
// holds its own valid bit and ready ripples back stage by stage, so bubbles
// close up and new operands are still taken while a result waits on the
// master side, until every stage is full.
`default_nettype none

module signed_restoring_divider_core #(
    parameter int WIDTH = sdiv_pkg::DEFAULT_WIDTH,
    localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // slave side
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,    // dividend, divisor, zero pad
    // master side
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata     // quotient, remainder, zero pad
);
    import sdiv_pkg::*;

    // Chain index k sits between the producer of stage k and its consumer
    t_ctrl            w_ctrl [0:WIDTH];
    logic [WIDTH-1:0] w_a    [0:WIDTH];
    logic [WIDTH-1:0] w_q    [0:WIDTH];
    logic [WIDTH-1:0] w_m    [0:WIDTH];
    logic             w_rdy  [0:WIDTH];
    logic [WIDTH-1:0] w_quotient;
    logic [WIDTH-1:0] w_remainder;

    // Partial remainder starts at zero
    assign w_a[0] = '0;

    sdiv_front #(.WIDTH(WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_tvalid),
        .o_ready    (s_tready),
        .i_dividend (s_tdata[WIDTH-1:0]),
        .i_divisor  (s_tdata[2*WIDTH-1:WIDTH]),
        .o_ctrl     (w_ctrl[0]),
        .o_q        (w_q[0]),
        .o_m        (w_m[0]),
        .i_rdy_next (w_rdy[0])
    );

    // One restoring step per cell
    for (genvar k = 0; k < WIDTH; k++) begin : g_cell
        sdiv_cell #(.WIDTH(WIDTH)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl[k]),
            .i_a        (w_a[k]),
            .i_q        (w_q[k]),
            .i_m        (w_m[k]),
            .o_ready    (w_rdy[k]),
            .o_ctrl     (w_ctrl[k+1]),
            .o_a        (w_a[k+1]),
            .o_q        (w_q[k+1]),
            .o_m        (w_m[k+1]),
            .i_rdy_next (w_rdy[k+1])
        );
    end

    sdiv_back #(.WIDTH(WIDTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl[WIDTH]),
        .i_a         (w_a[WIDTH]),
        .i_q         (w_q[WIDTH]),
        .o_ready     (w_rdy[WIDTH]),
        .o_valid     (m_tvalid),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder),
        .i_rdy_next  (m_tready)
    );

    // Divisor is not needed past the last cell
    assign m_tdata = TDATA_W'({w_remainder, w_quotient});

endmodule

`default_nettype wire

// ----- hdl/sdiv_front.sv -----
// Input stage: sign detection and operand magnitudes, registered.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_front #(
    parameter int WIDTH = sdiv_pkg::DEFAULT_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [WIDTH-1:0]   i_dividend,
    input  wire logic [WIDTH-1:0]   i_divisor,
    output sdiv_pkg::t_ctrl         o_ctrl,
    output logic [WIDTH-1:0]        o_q,
    output logic [WIDTH-1:0]        o_m,
    input  wire logic               i_rdy_next
);
    import sdiv_pkg::*;

    t_ctrl            r_ctrl;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_m;
    logic             w_load;
    logic             w_neg_n;
    logic             w_neg_d;

    assign w_load  = !r_ctrl.valid || i_rdy_next;
    assign w_neg_n = i_dividend[WIDTH-1];
    assign w_neg_d = i_divisor[WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (w_load) begin
            r_ctrl.valid <= i_valid;
            r_ctrl.neg   <= w_neg_n ^ w_neg_d;
        end
    end

    // Magnitudes; the most negative value maps onto itself
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_q <= w_neg_n ? (~i_dividend + 1'b1) : i_dividend;
            r_m <= w_neg_d ? (~i_divisor + 1'b1) : i_divisor;
        end
    end

    assign o_ready = w_load;
    assign o_ctrl  = r_ctrl;
    assign o_q     = r_q;
    assign o_m     = r_m;

endmodule

`default_nettype wire

// ----- hdl/sdiv_cell.sv -----
// One restoring step of the divider chain, registered.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_cell #(
    parameter int WIDTH = sdiv_pkg::DEFAULT_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sdiv_pkg::t_ctrl    i_ctrl,
    input  wire logic [WIDTH-1:0]   i_a,
    input  wire logic [WIDTH-1:0]   i_q,
    input  wire logic [WIDTH-1:0]   i_m,
    output logic                    o_ready,
    output sdiv_pkg::t_ctrl         o_ctrl,
    output logic [WIDTH-1:0]        o_a,
    output logic [WIDTH-1:0]        o_q,
    output logic [WIDTH-1:0]        o_m,
    input  wire logic               i_rdy_next
);
    import sdiv_pkg::*;

    t_ctrl            r_ctrl;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_m;
    logic [WIDTH-1:0] n_a;
    logic [WIDTH-1:0] n_q;
    logic [WIDTH-1:0] w_a_sh;
    logic [WIDTH-1:0] w_diff;
    logic             w_load;

    assign w_load = !r_ctrl.valid || i_rdy_next;

    // Shift, trial subtract, restore on a negative result
    always_comb begin
        w_a_sh = {i_a[WIDTH-2:0], i_q[WIDTH-1]};
        w_diff = w_a_sh - i_m;
        if (w_diff[WIDTH-1]) begin
            n_a = w_a_sh;
            n_q = {i_q[WIDTH-2:0], 1'b0};
        end else begin
            n_a = w_diff;
            n_q = {i_q[WIDTH-2:0], 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else if (w_load) begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_ctrl.valid) begin
            r_a <= n_a;
            r_q <= n_q;
            r_m <= i_m;
        end
    end

    assign o_ready = w_load;
    assign o_ctrl  = r_ctrl;
    assign o_a     = r_a;
    assign o_q     = r_q;
    assign o_m     = r_m;

endmodule

`default_nettype wire

// ----- hdl/sdiv_back.sv -----
// Output register: quotient sign fix-up and result hold for the master side.
// Depends on sdiv_pkg.
`default_nettype none

module sdiv_back #(
    parameter int WIDTH = sdiv_pkg::DEFAULT_WIDTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire sdiv_pkg::t_ctrl    i_ctrl,
    input  wire logic [WIDTH-1:0]   i_a,
    input  wire logic [WIDTH-1:0]   i_q,
    output logic                    o_ready,
    output logic                    o_valid,
    output logic [WIDTH-1:0]        o_quotient,
    output logic [WIDTH-1:0]        o_remainder,
    input  wire logic               i_rdy_next
);
    import sdiv_pkg::*;

    logic             r_valid;
    logic [WIDTH-1:0] r_quot;
    logic [WIDTH-1:0] r_rem;
    logic             w_load;

    assign w_load = !r_valid || i_rdy_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_ctrl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_ctrl.valid) begin
            r_quot <= i_ctrl.neg ? (~i_q + 1'b1) : i_q;
            r_rem  <= i_a;
        end
    end

    assign o_ready     = w_load;
    assign o_valid     = r_valid;
    assign o_quotient  = r_quot;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ----- hdl/sdiv_checker.sv -----
// Port-level checks for the signed restoring divider, bound to the top level.
// Depends on sdiv_pkg and signed_restoring_divider_core.
`default_nettype none

module sdiv_checker #(
    parameter int WIDTH = sdiv_pkg::DEFAULT_WIDTH,
    localparam int TDATA_W = ((2 * WIDTH + 7) / 8) * 8
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               s_tready,
    input wire logic               m_tvalid,
    input wire logic               m_tready,
    input wire logic [TDATA_W-1:0] m_tdata
);
    import sdiv_pkg::*;

    // Stalled result keeps its valid
    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result transaction dropped while stalled");

    // Stalled result keeps its data
    a_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result transaction changed while stalled");

    // With the output register empty every stage can advance
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_tvalid |-> s_tready)
        else $error("operands refused while output empty");

    // Nothing comes out straight after reset
    a_reset_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !m_tvalid)
        else $error("result valid straight after reset");

endmodule

bind signed_restoring_divider_core sdiv_checker #(.WIDTH(WIDTH)) u_sdiv_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for signed_restoring_divider_core (WIDTH = 16).
// Drives operand pairs over the slave stream, predicts quotient and remainder
// with a bit-exact restoring-division model and checks the master stream.
`timescale 1ns / 1ps

module tb_top;

    import sdiv_pkg::*;

    localparam int W           = DEFAULT_WIDTH;
    localparam int TDATA_W     = ((2 * W + 7) / 8) * 8;
    localparam int RAND_ITEMS  = 1530;
    localparam int PHASE_LEN   = 150;
    localparam int HOLD_CYCLES = 120;
    localparam int DRAIN_WAIT  = 2 * (W + 2) + 10;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

    // idle mixes stepped through by the random part
    typedef enum int {
        MIX_NONE,
        MIX_SEND_IDLE,
        MIX_RECV_STALL,
        MIX_BOTH
    } t_idle_mix;

    typedef struct packed {
        logic [W-1:0] quotient;
        logic [W-1:0] remainder;
    } t_quo_rem;

    typedef struct packed {
        logic [W-1:0] dividend;
        logic [W-1:0] divisor;
        logic         typed;     // expected value given in the row
        t_quo_rem     result;
    } t_div_row;

    localparam int N_ROWS = 25;

    logic               i_clk    = 1'b0;
    logic               i_rst_n  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;    // dividend, divisor
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;          // quotient, remainder

    t_quo_rem pending_q[$];
    t_div_row div_table [N_ROWS];
    int       n_fail       = 0;
    int       cycle_cnt    = 0;
    int       tx_idle_pct  = 0;
    int       rx_stall_pct = 0;
    int       rx_hold_left = 0;
    logic     rx_hold_tog  = 1'b0;    // flipped by the sequence to request a hold-off
    logic     rx_hold_seen = 1'b0;    // last request taken up by the receiver

    signed_restoring_divider_core #(
        .WIDTH (W)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Restoring division on sign magnitudes, bit for bit as the block does it.
    // Most negative operands keep their top bit after negation; left as is.
    function automatic t_quo_rem restore_divide(input logic [W-1:0] dvd,
                                                input logic [W-1:0] dvs);
        logic [W-1:0] part_rem;
        logic [W-1:0] quo;
        logic [W-1:0] mag;
        logic         neg_dvd;
        logic         neg_dvs;
        int           step;
        t_quo_rem     res;
        neg_dvd  = dvd[W-1];
        neg_dvs  = dvs[W-1];
        quo      = neg_dvd ? (~dvd + 1'b1) : dvd;
        mag      = neg_dvs ? (~dvs + 1'b1) : dvs;
        part_rem = '0;
        for (step = 0; step < W; step++) begin
            part_rem = {part_rem[W-2:0], quo[W-1]};
            quo      = {quo[W-2:0], 1'b0};
            part_rem = part_rem - mag;
            if (part_rem[W-1]) begin
                part_rem = part_rem + mag;     // restore, quotient bit stays 0
            end else begin
                quo[0] = 1'b1;
            end
        end
        if (neg_dvd != neg_dvs) begin
            quo = ~quo + 1'b1;
        end
        res.quotient  = quo;
        res.remainder = part_rem;
        return res;
    endfunction

    // Offer one operand pair, with random idle cycles ahead of it, and hold it
    // until the handshake. The expectation is queued at acceptance.
    task automatic send_division(input logic [W-1:0] dvd, input logic [W-1:0] dvs,
                                 input logic typed, input t_quo_rem typed_res);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'({dvs, dvd});
        do @(posedge i_clk); while (!s_tready);
        pending_q.insert(pending_q.size(), typed ? typed_res : restore_divide(dvd, dvs));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_q.size() != 0);
    endtask

    function automatic logic [W-1:0] rand_small();
        logic [W-1:0] v;
        v = W'($urandom_range(0, 40));
        return $urandom_range(1) ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [W-1:0] rand_corner();
        case ($urandom_range(4))
            0:       return '0;
            1:       return W'(1);
            2:       return '1;
            3:       return MOST_NEG;
            default: return MOST_POS;
        endcase
    endfunction

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (rx_hold_tog != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_tog;
            rx_hold_left <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left > 0) begin
            m_tready     <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Result checker: every accepted transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_quo_rem exp_res;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected: tdata %h", m_tdata);
                n_fail++;
            end else begin
                exp_res = pending_q.pop_front();
                if (m_tdata[W-1:0] !== exp_res.quotient) begin
                    $error("quotient: expected %0d, got %0d",
                           $signed(exp_res.quotient), $signed(m_tdata[W-1:0]));
                    n_fail++;
                end
                if (m_tdata[2*W-1:W] !== exp_res.remainder) begin
                    $error("remainder: expected %0d, got %0d",
                           exp_res.remainder, m_tdata[2*W-1:W]);
                    n_fail++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [W-1:0] dvd;
        logic [W-1:0] dvs;
        t_idle_mix    mix;
        int           pick;

        // typed rows: results obvious from the arithmetic; the rest predicted
        div_table = '{
            '{16'sd0,      16'sd1,      1'b1, '{16'sd0,      16'd0}},
            '{16'sd7,      16'sd2,      1'b1, '{16'sd3,      16'd1}},
            '{-16'sd7,     16'sd2,      1'b1, '{-16'sd3,     16'd1}},
            '{16'sd7,      -16'sd2,     1'b1, '{-16'sd3,     16'd1}},
            '{-16'sd7,     -16'sd2,     1'b1, '{16'sd3,      16'd1}},
            '{MOST_POS,    16'sd1,      1'b1, '{MOST_POS,    16'd0}},
            '{16'sd1,      MOST_POS,    1'b1, '{16'sd0,      16'd1}},
            '{16'sd100,    16'sd10,     1'b1, '{16'sd10,     16'd0}},
            '{-16'sd1,     16'sd1,      1'b1, '{-16'sd1,     16'd0}},
            '{MOST_POS,    MOST_POS,    1'b1, '{16'sd1,      16'd0}},
            '{-16'sd32767, MOST_POS,    1'b1, '{-16'sd1,     16'd0}},
            // zero divisor
            '{16'sd5,      16'sd0,      1'b0, '0},
            '{16'sd0,      16'sd0,      1'b0, '0},
            '{MOST_NEG,    16'sd0,      1'b0, '0},
            '{-16'sd1,     16'sd0,      1'b0, '0},
            // most negative operands
            '{MOST_NEG,    16'sd1,      1'b0, '0},
            '{MOST_NEG,    -16'sd1,     1'b0, '0},
            '{MOST_NEG,    MOST_NEG,    1'b0, '0},
            '{MOST_POS,    MOST_NEG,    1'b0, '0},
            '{16'sd1,      MOST_NEG,    1'b0, '0},
            '{MOST_NEG,    16'sd3,      1'b0, '0},
            '{16'sd12345,  MOST_NEG,    1'b0, '0},
            // all ones, alternating bits, one above most negative
            '{-16'sd1,     -16'sd1,     1'b0, '0},
            '{16'h5555,    16'h00AA,    1'b0, '0},
            '{-16'sd32767, 16'sd2,      1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling on either side
        for (int r = 0; r < N_ROWS; r++) begin
            send_division(div_table[r].dividend, div_table[r].divisor,
                          div_table[r].typed, div_table[r].result);
        end
        wait_drained();

        // random part: idle mix changes every phase, pipe drained in between
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % PHASE_LEN == 0) begin
                wait_drained();
                mix = t_idle_mix'((n / PHASE_LEN) % 4);
                case (mix)
                    MIX_NONE:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    MIX_SEND_IDLE:  begin tx_idle_pct = 78; rx_stall_pct = 0;  end
                    MIX_RECV_STALL: begin tx_idle_pct = 0;  rx_stall_pct = 78; end
                    default:        begin tx_idle_pct = 30; rx_stall_pct = 30; end
                endcase
                // long hold-off on the master side: the pipe fills and s_tready drops
                if (mix == MIX_NONE) begin
                    rx_hold_tog <= ~rx_hold_tog;
                end
            end
            pick = $urandom_range(99);
            if (pick < 45) begin
                dvd = W'($urandom);
                dvs = W'($urandom);
            end else if (pick < 65) begin
                dvd = W'($urandom);
                dvs = rand_small();
            end else if (pick < 75) begin
                dvd = rand_small();
                dvs = rand_small();
            end else if (pick < 87) begin
                dvd = $urandom_range(1) ? rand_corner() : W'($urandom);
                dvs = rand_corner();
            end else if (pick < 93) begin
                dvd = W'($urandom);
                dvs = '0;
            end else begin
                // divisor magnitude at or above half range: at most one quotient step succeeds
                dvd = W'($urandom);
                dvs = {($urandom_range(1) ? 2'b10 : 2'b01), (W-2)'($urandom)};
            end
            send_division(dvd, dvs, 1'b0, '0);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_q.size() != 0) begin
            $error("%0d expected results never arrived", pending_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sdiv_pkg.sv
hdl/sdiv_front.sv
hdl/sdiv_cell.sv
hdl/sdiv_back.sv
hdl/signed_restoring_divider_core.sv
hdl/sdiv_checker.sv
dv/tb_top.sv
